### rtl/command_frame_receiver_crc16_unit_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef COMMAND_FRAME_RECEIVER_CRC16_UNIT_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_CRC16_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CFR_ASSERT_HOLD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cfr_pkg.sv
package cfr_pkg;

    localparam int unsigned DEF_RECORD_LEN = 60;
    localparam int unsigned DEF_BUFFER_LEN = 64;

    localparam int unsigned COUNT_W = 7;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned CRC_W   = 16;

    localparam logic [7:0]       CMD_WRITE  = 8'h03;
    localparam logic [7:0]       CMD_READ   = 8'h04;
    localparam logic [7:0]       CMD_SENSOR = 8'h40;
    localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_READ    = 2'd2,
        KIND_SENSOR  = 2'd3
    } t_frame_kind;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] data_byte;
    } t_byte_item;

    typedef struct packed {
        logic [POS_W-1:0] byte_position;
        logic             frame_done;
        logic             crc_ok;
        t_frame_kind      frame_kind;
        logic             overflow;
    } t_result_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         cmd;
        logic [CRC_W-1:0]   crc;
        logic               complete;
    } t_frame_state;

    // CRC-16/CCITT, MSB first, one byte per call.
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic t_frame_kind kind_of(input logic [7:0] cmd);
        t_frame_kind k;
        case (cmd)
            CMD_WRITE:  k = KIND_WRITE;
            CMD_READ:   k = KIND_READ;
            CMD_SENSOR: k = KIND_SENSOR;
            default:    k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

### rtl/cfr_if.sv
interface cfr_byte_if;
    import cfr_pkg::*;

    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] data_byte;

    modport source (output valid, output frame_start, output data_byte, input ready);
    modport sink   (input valid, input frame_start, input data_byte, output ready);
endinterface

interface cfr_result_if;
    import cfr_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] byte_position;
    logic             frame_done;
    logic             crc_ok;
    logic [1:0]       frame_kind;
    logic             overflow;

    modport source (output valid, output byte_position, output frame_done,
                    output crc_ok, output frame_kind, output overflow, input ready);
    modport sink   (input valid, input byte_position, input frame_done,
                    input crc_ok, input frame_kind, input overflow, output ready);
endinterface

### rtl/cfr_frame_core.sv
module cfr_frame_core #(
    parameter int unsigned RECORD_LEN = cfr_pkg::DEF_RECORD_LEN,
    parameter int unsigned BUFFER_LEN = cfr_pkg::DEF_BUFFER_LEN
) (
    input  cfr_pkg::t_frame_state i_state,
    input  cfr_pkg::t_byte_item   i_item,
    output cfr_pkg::t_frame_state o_state,
    output cfr_pkg::t_result_item o_result
);
    import cfr_pkg::*;

    localparam logic [COUNT_W-1:0] WriteLen  = COUNT_W'(RECORD_LEN + 4);
    localparam logic [COUNT_W-1:0] ReadLen   = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] SensorLen = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] BufLen    = COUNT_W'(BUFFER_LEN);
    localparam logic [POS_W-1:0]   LastPos   = POS_W'(BUFFER_LEN - 1);

    function automatic logic [COUNT_W-1:0] length_of(input logic [7:0] cmd);
        logic [COUNT_W-1:0] len;
        case (cmd)
            CMD_WRITE:  len = WriteLen;
            CMD_READ:   len = ReadLen;
            CMD_SENSOR: len = SensorLen;
            default:    len = '0;
        endcase
        return len;
    endfunction

    always_comb begin
        t_frame_state       s;
        logic [COUNT_W-1:0] cnt_inc;
        logic [COUNT_W-1:0] len;

        s = i_state;
        // start marker clears the frame before this byte is looked at
        if (i_item.frame_start) begin
            s.count    = '0;
            s.crc      = CRC_INIT;
            s.complete = 1'b0;
        end

        o_result = '0;
        cnt_inc  = s.count + COUNT_W'(1);
        len      = '0;

        if (s.complete) begin
            // trailing byte after completion: ignored
            len                    = length_of(s.cmd);
            o_result.byte_position = len[POS_W-1:0];
        end else if (s.count >= BufLen) begin
            o_result.overflow      = 1'b1;
            o_result.byte_position = LastPos;
        end else begin
            o_result.byte_position = s.count[POS_W-1:0];
            if (s.count == '0) begin
                s.cmd = i_item.data_byte;
            end
            s.crc   = crc_update(s.crc, i_item.data_byte);
            s.count = cnt_inc;
            len     = length_of(s.cmd);
            if (len != '0 && cnt_inc == len) begin
                s.complete          = 1'b1;
                o_result.frame_done = 1'b1;
                o_result.crc_ok     = (s.crc == '0);
            end
        end

        o_result.frame_kind = kind_of(s.cmd);
        o_state             = s;
    end

endmodule

### rtl/command_frame_receiver_crc16_unit.sv
// Command frame receiver with CRC-16/CCITT check.
// i_byte carries received serial bytes; frame_start marks the first byte of
// a frame (the command byte). The command selects the frame length: program
// write is RECORD_LEN+4 bytes, program read 4, sensor read 8. Each accepted
// byte yields exactly one transaction on o_result with its position, the
// frame kind, frame_done on the last byte with crc_ok when the CRC residue
// over the whole frame is zero, and overflow when the buffer was full.
// Pipeline: a byte accepted on i_byte is held in the input register; once
// the result slot is free it is processed and its result is registered.
// Throughput: one byte per cycle while o_result is not stalled; the
// byte-wise CRC update and length compare lie between the two registers.
// Reset (synchronous, active low) empties both registers and restores the
// frame state: count 0, command 0, CRC 0xFFFF, not complete.
// When o_result stalls, the result register holds and the input register
// takes one more byte; i_byte.ready drops once both are occupied.
`include "command_frame_receiver_crc16_unit_assert.svh"

module command_frame_receiver_crc16_unit #(
    parameter int unsigned RECORD_LEN = cfr_pkg::DEF_RECORD_LEN,
    parameter int unsigned BUFFER_LEN = cfr_pkg::DEF_BUFFER_LEN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cfr_byte_if.sink     i_byte,
    cfr_result_if.source o_result
);
    import cfr_pkg::*;

    // input register stage
    logic         r_in_valid;
    t_byte_item   r_in;
    // result register stage
    logic         r_out_valid;
    t_result_item r_res;
    // frame state, updated as a byte moves into the result register
    t_frame_state r_state;

    t_frame_state n_state;
    t_result_item n_res;
    t_byte_item   w_in_item;
    logic         w_adv;
    logic         w_fire;
    logic         w_accept;

    assign w_in_item.frame_start = i_byte.frame_start;
    assign w_in_item.data_byte   = i_byte.data_byte;

    // result slot free or being drained this cycle
    assign w_adv    = !r_out_valid || o_result.ready;
    assign w_fire   = r_in_valid && w_adv;
    assign i_byte.ready = !r_in_valid || w_adv;
    assign w_accept = i_byte.valid && i_byte.ready;

    cfr_frame_core #(
        .RECORD_LEN (RECORD_LEN),
        .BUFFER_LEN (BUFFER_LEN)
    ) u_core (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{count: '0, cmd: '0, crc: CRC_INIT, complete: 1'b0};
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= w_in_item;
        end
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.byte_position = r_res.byte_position;
    assign o_result.frame_done    = r_res.frame_done;
    assign o_result.crc_ok        = r_res.crc_ok;
    assign o_result.frame_kind    = r_res.frame_kind;
    assign o_result.overflow      = r_res.overflow;

    // a completing byte is never a dropped one
    `CFR_ASSERT_HOLD(a_done_no_ovf, i_clk, i_rst_n, !o_result.valid || !(o_result.frame_done && o_result.overflow), "frame_done with overflow")
    // crc_ok only reported on completion
    `CFR_ASSERT_HOLD(a_ok_needs_done, i_clk, i_rst_n, !o_result.valid || o_result.frame_done || !o_result.crc_ok, "crc_ok without frame_done")
    // byte count never runs past the buffer
    `CFR_ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, r_state.count <= COUNT_W'(BUFFER_LEN), "byte count beyond buffer")
    // a start byte lands at position zero and is never dropped
    `CFR_ASSERT_NEXT(a_start_pos, i_clk, i_rst_n, w_fire && r_in.frame_start, o_result.valid && o_result.byte_position == '0 && !o_result.overflow, "start byte misplaced")

endmodule
